// ===== rtl/bgr_pkg.sv =====
// Package for the bitmap glyph row generator.
// Holds the action and state codes, font geometry constants and the
// font store access structs. No dependencies.
package bgr_pkg;

  localparam int GLYPH_ROWS  = 16;
  localparam int ROW_W       = 4;
  localparam int ZONE_GLYPHS = 94;
  localparam int STORE_AW    = 20;   // byte address width, covers the largest wide store
  localparam int WORD_AW     = 19;   // wide word (row) address width
  localparam int GLYPH_W     = 15;   // wide glyph index width (94*254+254 fits)

  localparam logic [7:0]       OFFSET_RESET = 8'd160;
  localparam logic [ROW_W-1:0] LAST_ROW     = 4'd15;

  typedef enum logic [1:0] {
    ACT_LOAD_NARROW = 2'd0,
    ACT_LOAD_WIDE   = 2'd1,
    ACT_DRAW_NARROW = 2'd2,
    ACT_DRAW_WIDE   = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DRAW = 1'b1
  } state_t;

  typedef struct packed {
    logic                narrow_en;
    logic                wide_en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } font_wr_t;

  typedef struct packed {
    logic               en;
    logic [11:0]        narrow_idx;
    logic [WORD_AW-1:0] wide_word;
  } font_rd_t;

endpackage

// ===== rtl/bgr_font_store.sv =====
// Font storage: narrow 8x16 font bytes and the wide 16x16 font split into
// even and odd byte banks so one read returns a whole 16-bit row.
// Depends on bgr_pkg.
module bgr_font_store #(
  parameter int NARROW_BYTES = 4096,
  parameter int WIDE_BYTES   = 262144
) (
  input  logic             clk,
  input  bgr_pkg::font_wr_t wr,
  input  bgr_pkg::font_rd_t rd,
  output logic [7:0]       narrow_q,
  output logic [15:0]      wide_q
);
  import bgr_pkg::*;

  localparam int NAW        = $clog2(NARROW_BYTES);
  localparam int EVEN_DEPTH = (WIDE_BYTES + 1) / 2;
  localparam int ODD_DEPTH  = WIDE_BYTES / 2;
  localparam int WAW        = $clog2(EVEN_DEPTH);

  logic [7:0] narrow_mem [NARROW_BYTES];
  logic [7:0] even_mem   [EVEN_DEPTH];
  logic [7:0] odd_mem    [ODD_DEPTH];

  logic [7:0] even_q;
  logic [7:0] odd_q;

  always_ff @(posedge clk) begin
    if (wr.narrow_en) begin
      narrow_mem[wr.addr[NAW-1:0]] <= wr.data;
    end
    if (wr.wide_en) begin
      if (wr.addr[0]) begin
        odd_mem[wr.addr[WAW:1]] <= wr.data;
      end else begin
        even_mem[wr.addr[WAW:1]] <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      narrow_q <= narrow_mem[rd.narrow_idx[NAW-1:0]];
      even_q   <= even_mem[rd.wide_word[WAW-1:0]];
      odd_q    <= odd_mem[rd.wide_word[WAW-1:0]];
    end
  end

  assign wide_q = {even_q, odd_q};

endmodule

// ===== rtl/bitmap_glyph_row_generator.sv =====
// Bitmap glyph row generator. A load request writes one font byte. A draw
// request produces sixteen row results, top row first, one per cycle while the
// output does not stall: the font store has a registered read port and each
// cycle reads one glyph row. A draw occupies the block for the accepting
// cycle, sixteen row reads, and the move of the last row from the read stage
// into the output register; a new request is taken after that. The first row
// passes through the font store read stage and then the output register.
// Output stalls hold the read stage and pause the row reads. Font stores come up
// undefined; a glyph must be loaded before it is drawn. Built on bgr_pkg and
// bgr_font_store.
module bitmap_glyph_row_generator #(
  parameter int NARROW_GLYPH_COUNT = 256,
  parameter int WIDE_STORE_BYTES   = 262144
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [17:0]        font_address,
  input  logic [7:0]         font_byte,
  input  logic [7:0]         char_code,
  input  logic [7:0]         zone_byte,
  input  logic [7:0]         position_byte,
  input  logic signed [15:0] left_x,
  input  logic signed [15:0] top_y,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] row_x,
  output logic signed [15:0] row_y,
  output logic [15:0]        row_mask,
  output logic               wide_row,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               last_row
);
  import bgr_pkg::*;

  localparam int NARROW_BYTES = NARROW_GLYPH_COUNT * GLYPH_ROWS;
  localparam int WIDE_GLYPHS  = WIDE_STORE_BYTES / (2 * GLYPH_ROWS);
  localparam logic [8:0]          NARROW_LIMIT = 9'(NARROW_GLYPH_COUNT);
  localparam logic [STORE_AW:0]   NARROW_BYTES_LIMIT = (STORE_AW+1)'(NARROW_BYTES);
  localparam logic [STORE_AW:0]   WIDE_BYTES_LIMIT   = (STORE_AW+1)'(WIDE_STORE_BYTES);
  localparam logic [GLYPH_W:0]    WIDE_GLYPH_LIMIT   = (GLYPH_W+1)'(WIDE_GLYPHS);

  state_t state, state_next;

  logic [7:0]         code_offset;
  logic [ROW_W-1:0]   row;
  logic               rd_vld;
  logic [ROW_W-1:0]   rd_row;

  logic               ctx_wide;
  logic               ctx_blank;
  logic [7:0]         ctx_code;
  logic [GLYPH_W-1:0] ctx_glyph;
  logic [15:0]        ctx_x;
  logic [15:0]        ctx_y;
  logic [7:0]         ctx_red;
  logic [7:0]         ctx_green;
  logic [7:0]         ctx_blue;

  action_t            act;
  logic               accept;
  logic               is_draw;
  logic               out_free;
  logic               issue;
  logic               zone_ok;
  logic               pos_ok;
  logic [7:0]         zone_m1;
  logic [7:0]         pos_m1;
  logic [GLYPH_W-1:0] glyph_idx;
  logic               wide_blank;
  logic               narrow_blank;
  logic [STORE_AW:0]  load_addr;

  font_wr_t           fwr;
  font_rd_t           frd;
  logic [7:0]         narrow_q;
  logic [15:0]        wide_q;

  assign act      = action_t'(action);
  assign in_ready = (state == ST_IDLE) && !rd_vld;
  assign accept   = in_valid && in_ready;
  assign is_draw  = (act == ACT_DRAW_NARROW) || (act == ACT_DRAW_WIDE);
  assign out_free = !out_valid || out_ready;
  assign issue    = (state == ST_DRAW) && (!rd_vld || out_free);

  // zone/position numbers are one-based; zero or below means a blank glyph
  assign zone_ok      = zone_byte > code_offset;
  assign pos_ok       = position_byte > code_offset;
  assign zone_m1      = zone_byte - code_offset - 8'd1;
  assign pos_m1       = position_byte - code_offset - 8'd1;
  assign glyph_idx    = GLYPH_W'(zone_m1) * GLYPH_W'(ZONE_GLYPHS) + GLYPH_W'(pos_m1);
  assign wide_blank   = !zone_ok || !pos_ok || ({1'b0, glyph_idx} >= WIDE_GLYPH_LIMIT);
  assign narrow_blank = {1'b0, char_code} >= NARROW_LIMIT;

  assign load_addr = (STORE_AW+1)'(font_address);

  always_comb begin
    fwr.narrow_en = accept && (act == ACT_LOAD_NARROW) && (load_addr < NARROW_BYTES_LIMIT);
    fwr.wide_en   = accept && (act == ACT_LOAD_WIDE) && (load_addr < WIDE_BYTES_LIMIT);
    fwr.addr      = load_addr[STORE_AW-1:0];
    fwr.data      = font_byte;
    frd.en         = issue;
    frd.narrow_idx = {ctx_code, row};
    frd.wide_word  = {ctx_glyph, row};
  end

  bgr_font_store #(
    .NARROW_BYTES (NARROW_BYTES),
    .WIDE_BYTES   (WIDE_STORE_BYTES)
  ) u_store (
    .clk      (clk),
    .wr       (fwr),
    .rd       (frd),
    .narrow_q (narrow_q),
    .wide_q   (wide_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_draw) state_next = ST_DRAW;
      end
      ST_DRAW: begin
        if (issue && (row == LAST_ROW)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_offset <= OFFSET_RESET;
    end else if (cfg_we) begin
      code_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (accept) begin
        row <= '0;
      end else if (issue) begin
        row <= row + ROW_W'(1);
      end
      if (issue) begin
        rd_vld <= 1'b1;
      end else if (out_free) begin
        rd_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_row <= row;
    end
  end

  // request context, held until the draw has left the read stage
  always_ff @(posedge clk) begin
    if (accept && is_draw) begin
      ctx_wide  <= (act == ACT_DRAW_WIDE);
      ctx_blank <= (act == ACT_DRAW_WIDE) ? wide_blank : narrow_blank;
      ctx_code  <= char_code;
      ctx_glyph <= glyph_idx;
      ctx_x     <= left_x;
      ctx_y     <= top_y;
      ctx_red   <= red;
      ctx_green <= green;
      ctx_blue  <= blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_vld && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && out_free) begin
      row_x     <= ctx_x;
      row_y     <= ctx_y + 16'(rd_row);
      wide_row  <= ctx_wide;
      out_red   <= ctx_red;
      out_green <= ctx_green;
      out_blue  <= ctx_blue;
      last_row  <= (rd_row == LAST_ROW);
      if (ctx_blank) begin
        row_mask <= '0;
      end else if (ctx_wide) begin
        row_mask <= wide_q;
      end else begin
        row_mask <= {narrow_q, 8'h00};
      end
    end
  end

  a_read_held: assert property (@(posedge clk) disable iff (rst)
    rd_vld && !out_free |=> rd_vld && $stable(rd_row))
    else $error("read stage lost a row while output stalled");

  a_draw_start: assert property (@(posedge clk) disable iff (rst)
    accept && is_draw |=> state == ST_DRAW && row == '0 && !rd_vld)
    else $error("draw did not start at row zero");

  a_draw_end: assert property (@(posedge clk) disable iff (rst)
    issue && row == LAST_ROW |=> state == ST_IDLE && rd_vld && rd_row == LAST_ROW)
    else $error("draw did not end after the last row read");

endmodule

// ===== bench/bgr_row_checker.sv =====
// Row checker for the bitmap glyph row generator: tracks font loads and the
// code offset, predicts the sixteen rows of each draw request and compares them.
// Depends on bgr_pkg.
module bgr_row_checker #(
  parameter int NARROW_GLYPH_COUNT = 256,
  parameter int WIDE_STORE_BYTES   = 262144
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         action,
  input  logic [17:0]        font_address,
  input  logic [7:0]         font_byte,
  input  logic [7:0]         char_code,
  input  logic [7:0]         zone_byte,
  input  logic [7:0]         position_byte,
  input  logic signed [15:0] left_x,
  input  logic signed [15:0] top_y,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] row_x,
  input  logic signed [15:0] row_y,
  input  logic [15:0]        row_mask,
  input  logic               wide_row,
  input  logic [7:0]         out_red,
  input  logic [7:0]         out_green,
  input  logic [7:0]         out_blue,
  input  logic               last_row,
  output int                 mismatches,
  output int                 rows_pending
);
  import bgr_pkg::*;

  localparam int NARROW_BYTES     = NARROW_GLYPH_COUNT * GLYPH_ROWS;
  localparam int WIDE_GLYPH_BYTES = 2 * GLYPH_ROWS;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        mask;
    logic               wide;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic               last;
  } glyph_row_t;

  logic [7:0] narrow_font [NARROW_BYTES];
  logic [7:0] wide_font [WIDE_STORE_BYTES];
  logic [7:0] code_offset;
  glyph_row_t rows_due [$];

  // Pixel bits of one glyph row, top bit leftmost; blank when the code misses.
  function automatic logic [15:0] glyph_row_bits(logic [1:0] act, logic [7:0] code,
                                                 logic [7:0] zb, logic [7:0] pb, int row);
    int zone, pos, base;
    if (act == ACT_DRAW_NARROW) begin
      if (code >= NARROW_GLYPH_COUNT) return '0;
      return {narrow_font[int'(code) * GLYPH_ROWS + row], 8'h00};
    end
    zone = int'(zb) - int'(code_offset);
    pos  = int'(pb) - int'(code_offset);
    if (zone <= 0 || pos <= 0) return '0;
    // position is not limited to a zone; it runs on linearly
    base = (ZONE_GLYPHS * (zone - 1) + pos - 1) * WIDE_GLYPH_BYTES;
    if (base + WIDE_GLYPH_BYTES > WIDE_STORE_BYTES) return '0;
    return {wide_font[base + 2 * row], wide_font[base + 2 * row + 1]};
  endfunction

  always @(posedge clk) begin
    glyph_row_t want, got;
    if (rst) begin
      code_offset = OFFSET_RESET;
      rows_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) code_offset = cfg_data;
      if (out_valid && out_ready) begin
        got = {row_x, row_y, row_mask, wide_row, out_red, out_green, out_blue, last_row};
        if (rows_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected row x=%0d y=%0d mask=%h with no draw pending",
                     got.x, got.y, got.mask);
        end else begin
          want = rows_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("row mismatch: want x=%0d y=%0d mask=%h wide=%b rgb=%h%h%h last=%b",
                       want.x, want.y, want.mask, want.wide, want.r, want.g, want.b,
                       want.last);
              $display("              got  x=%0d y=%0d mask=%h wide=%b rgb=%h%h%h last=%b",
                       got.x, got.y, got.mask, got.wide, got.r, got.g, got.b, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        case (action)
          ACT_LOAD_NARROW: begin
            // loads past the store are dropped
            if (font_address < NARROW_BYTES) narrow_font[font_address] = font_byte;
          end
          ACT_LOAD_WIDE: begin
            if (font_address < WIDE_STORE_BYTES) wide_font[font_address] = font_byte;
          end
          default: begin
            for (int r = 0; r < GLYPH_ROWS; r++) begin
              want.x    = left_x;
              want.y    = top_y + 16'(r);
              want.mask = glyph_row_bits(action, char_code, zone_byte, position_byte, r);
              want.wide = (action == ACT_DRAW_WIDE);
              want.r    = red;
              want.g    = green;
              want.b    = blue;
              want.last = (r == GLYPH_ROWS - 1);
              rows_due.push_back(want);
            end
          end
        endcase
      end
    end
    rows_pending = rows_due.size();
  end

endmodule

// ===== bench/bitmap_glyph_row_generator_tb.sv =====
// Testbench top for the bitmap glyph row generator: loads fonts, issues draw
// requests under several idle patterns and code offsets, and gives the verdict.
// Depends on bgr_pkg, bitmap_glyph_row_generator and bgr_row_checker.
module bitmap_glyph_row_generator_tb;
  import bgr_pkg::*;

  localparam int NARROW_GLYPH_COUNT = 256;
  localparam int WIDE_STORE_BYTES   = 262144;
  localparam int NARROW_BYTES       = NARROW_GLYPH_COUNT * GLYPH_ROWS;
  localparam int WIDE_GLYPH_BYTES   = 2 * GLYPH_ROWS;
  localparam int WIDE_GLYPHS        = WIDE_STORE_BYTES / WIDE_GLYPH_BYTES;
  localparam int PHASES             = 5;
  localparam int ITEMS_PER_PHASE    = 45;
  localparam int HOLD_CYCLES        = 300;
  localparam int SETTLE_CYCLES      = 24;
  localparam int STALL_LIMIT        = 2000;

  typedef struct packed {
    action_t            act;
    logic [17:0]        addr;
    logic [7:0]         data;
    logic [7:0]         code;
    logic [7:0]         zb;
    logic [7:0]         pb;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } glyph_req_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [7:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         action;
  logic [17:0]        font_address;
  logic [7:0]         font_byte;
  logic [7:0]         char_code;
  logic [7:0]         zone_byte;
  logic [7:0]         position_byte;
  logic signed [15:0] left_x;
  logic signed [15:0] top_y;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] row_x;
  logic signed [15:0] row_y;
  logic [15:0]        row_mask;
  logic               wide_row;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic               last_row;
  int                 mismatches;
  int                 rows_pending;

  int valid_gap_pct;
  int ready_drop_pct;
  bit hold_output;
  int code_offset_now;
  int items_sent;
  int narrow_codes [$];
  int wide_glyphs [$];
  bit wide_written [WIDE_STORE_BYTES];

  bitmap_glyph_row_generator #(
    .NARROW_GLYPH_COUNT(NARROW_GLYPH_COUNT),
    .WIDE_STORE_BYTES  (WIDE_STORE_BYTES)
  ) DUT (.*);

  bgr_row_checker #(
    .NARROW_GLYPH_COUNT(NARROW_GLYPH_COUNT),
    .WIDE_STORE_BYTES  (WIDE_STORE_BYTES)
  ) row_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] font_bits();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] screen_coord();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh7FF8;  // rows wrap past the positive limit
      3:       return -16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic glyph_req_t random_req(action_t act);
    glyph_req_t q;
    q.act  = act;
    q.addr = 18'($urandom);
    q.data = font_bits();
    q.code = 8'($urandom);
    q.zb   = 8'($urandom);
    q.pb   = 8'($urandom);
    q.x    = screen_coord();
    q.y    = screen_coord();
    q.r    = font_bits();
    q.g    = font_bits();
    q.b    = font_bits();
    return q;
  endfunction

  function automatic bit wide_glyph_loaded(int g);
    for (int i = 0; i < WIDE_GLYPH_BYTES; i++)
      if (!wide_written[g * WIDE_GLYPH_BYTES + i]) return 1'b0;
    return 1'b1;
  endfunction

  // True when a wide draw with this code reads no unwritten font byte.
  function automatic bit wide_code_safe(logic [7:0] zb, logic [7:0] pb);
    int zone, pos, g;
    zone = int'(zb) - code_offset_now;
    pos  = int'(pb) - code_offset_now;
    if (zone <= 0 || pos <= 0) return 1'b1;
    g = ZONE_GLYPHS * (zone - 1) + pos - 1;
    return g >= WIDE_GLYPHS || wide_glyph_loaded(g);
  endfunction

  // Picks one of the zone/position pairs that address glyph g; positions past
  // one zone are allowed, so zone can trade for position in steps of a zone.
  function automatic bit code_for_glyph(int g, output logic [7:0] zb, output logic [7:0] pb);
    int zone0, pos0, k;
    int fits [$];
    zone0 = g / ZONE_GLYPHS;
    pos0  = g % ZONE_GLYPHS;
    for (k = 0; k <= zone0; k++)
      if (code_offset_now + 1 + zone0 - k <= 255 &&
          code_offset_now + 1 + pos0 + ZONE_GLYPHS * k <= 255)
        fits.push_back(k);
    if (fits.size() == 0) return 1'b0;
    k  = fits[$urandom_range(fits.size() - 1)];
    zb = 8'(code_offset_now + 1 + zone0 - k);
    pb = 8'(code_offset_now + 1 + pos0 + ZONE_GLYPHS * k);
    return 1'b1;
  endfunction

  task automatic send_req(input glyph_req_t q);
    @(negedge clk);
    while ($urandom_range(99) < valid_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    action        <= q.act;
    font_address  <= q.addr;
    font_byte     <= q.data;
    char_code     <= q.code;
    zone_byte     <= q.zb;
    position_byte <= q.pb;
    left_x        <= q.x;
    top_y         <= q.y;
    red           <= q.r;
    green         <= q.g;
    blue          <= q.b;
    do @(posedge clk); while (!in_ready);
    if (!(q.act == ACT_LOAD_NARROW && q.addr >= NARROW_BYTES)) items_sent++;
    if (q.act == ACT_LOAD_WIDE) wide_written[q.addr] = 1'b1;
  endtask

  task automatic load_narrow_glyph(input logic [7:0] code);
    glyph_req_t q;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      q      = random_req(ACT_LOAD_NARROW);
      q.addr = 18'(int'(code) * GLYPH_ROWS + r);
      send_req(q);
    end
    narrow_codes.push_back(code);
  endtask

  task automatic load_wide_glyph(input int g);
    glyph_req_t q;
    for (int i = 0; i < WIDE_GLYPH_BYTES; i++) begin
      q      = random_req(ACT_LOAD_WIDE);
      q.addr = 18'(g * WIDE_GLYPH_BYTES + i);
      send_req(q);
    end
    wide_glyphs.push_back(g);
  endtask

  task automatic draw_narrow(input logic [7:0] code);
    glyph_req_t q;
    q      = random_req(ACT_DRAW_NARROW);
    q.code = code;
    send_req(q);
  endtask

  task automatic draw_wide(input logic [7:0] zb, input logic [7:0] pb);
    glyph_req_t q;
    q    = random_req(ACT_DRAW_WIDE);
    q.zb = zb;
    q.pb = pb;
    send_req(q);
  endtask

  // Random code; mostly blank (at or under the offset, or past the store).
  task automatic stray_wide_draw();
    logic [7:0] zb, pb;
    do begin
      zb = 8'($urandom);
      pb = 8'($urandom);
      if ($urandom_range(3) == 0) zb = 8'(code_offset_now);
    end while (!wide_code_safe(zb, pb));
    draw_wide(zb, pb);
  endtask

  task automatic random_step();
    int pick, g, span;
    logic [7:0] zb, pb;
    glyph_req_t q;
    pick = $urandom_range(99);
    if (pick < 35) begin
      draw_narrow(8'(narrow_codes[$urandom_range(narrow_codes.size() - 1)]));
    end else if (pick < 70) begin
      g = wide_glyphs[$urandom_range(wide_glyphs.size() - 1)];
      if (code_for_glyph(g, zb, pb)) draw_wide(zb, pb);
      else stray_wide_draw();
    end else if (pick < 80) begin
      stray_wide_draw();
    end else if (pick < 83) begin
      load_narrow_glyph(8'($urandom));
    end else if (pick < 86) begin
      span = 255 - code_offset_now;
      if (span > 0) begin
        g = ZONE_GLYPHS * ($urandom_range(1, span < 88 ? span : 88) - 1) +
            $urandom_range(1, span) - 1;
        if (g < WIDE_GLYPHS) load_wide_glyph(g);
      end
    end else if (pick < 93) begin
      q = random_req(ACT_LOAD_NARROW);
      if ($urandom_range(1)) q.addr = 18'($urandom_range(NARROW_BYTES - 1));
      send_req(q);
    end else begin
      send_req(random_req(ACT_LOAD_WIDE));
    end
  endtask

  // Waits until every row has arrived and the block has had time to go idle.
  task automatic drain_rows();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_offset(input logic [7:0] value);
    drain_rows();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    code_offset_now = value;
  endtask

  // Output side: random stalls, plus one long hold to back up the input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= ready_drop_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int target;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    action          = ACT_LOAD_NARROW;
    font_address    = '0;
    font_byte       = '0;
    char_code       = '0;
    zone_byte       = '0;
    position_byte   = '0;
    left_x          = '0;
    top_y           = '0;
    red             = '0;
    green           = '0;
    blue            = '0;
    valid_gap_pct   = 0;
    ready_drop_pct  = 0;
    hold_output     = 1'b0;
    code_offset_now = OFFSET_RESET;
    items_sent      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset offset.
    load_narrow_glyph(8'h00);
    load_narrow_glyph(8'hFF);
    load_wide_glyph(0);
    load_wide_glyph(ZONE_GLYPHS);
    load_wide_glyph(WIDE_GLYPHS - 1);
    begin
      glyph_req_t q;
      q      = random_req(ACT_LOAD_NARROW);
      q.addr = 18'(NARROW_BYTES);
      send_req(q);
      q.addr = '1;
      send_req(q);
      q      = random_req(ACT_DRAW_NARROW);
      q.code = 8'h00;
      q.x    = 16'sh8000;
      q.y    = 16'sh7FFF;
      send_req(q);
      q.code = 8'hFF;
      q.x    = 16'sh7FFF;
      q.y    = 16'sh8000;
      {q.r, q.g, q.b} = '0;
      send_req(q);
      {q.r, q.g, q.b} = '1;
      send_req(q);
    end
    draw_wide(8'd161, 8'd161);  // first glyph
    draw_wide(8'd248, 8'd174);  // last glyph in the store
    draw_wide(8'd248, 8'd175);  // one past the store: blank
    draw_wide(8'd161, 8'd255);  // position beyond one zone
    draw_wide(8'd162, 8'd161);  // same glyph through the next zone
    draw_wide(8'd160, 8'd161);  // zone at the offset: blank
    draw_wide(8'd161, 8'd160);  // position at the offset: blank
    draw_wide(8'd0, 8'd0);
    draw_wide(8'd255, 8'd255);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       write_offset(8'd0);
        2:       write_offset(8'd255);
        3:       write_offset(8'($urandom_range(1, 254)));
        4:       write_offset(8'd161);
        default: ;
      endcase
      valid_gap_pct  = (p == 1) ? 63 : (p == 3) ? 16 : 0;
      ready_drop_pct = (p == 2) ? 63 : (p == 3) ? 16 : 0;
      if (p == 0) hold_output = 1'b1;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) random_step();
    end
    drain_rows();

    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
